// File: src/iph_pkg.sv
// ----------------------------------------------------------------------------
// iph_pkg
// Shared types and constants for the IR pulse pattern hash block.
// ----------------------------------------------------------------------------
package iph_pkg;

    // Width of one captured duration
    localparam int DURATION_BITS = 16;
    // Width of the tolerance products (value * 10 needs four more bits)
    localparam int PROD_BITS     = DURATION_BITS + 4;

    localparam int HASH_BITS     = 32;
    localparam int COUNT_BITS    = 8;

    // FNV-1 constants
    localparam logic [HASH_BITS-1:0]  HASH_PRIME  = 32'd16777619;
    localparam logic [HASH_BITS-1:0]  HASH_BASIS  = 32'd2166136261;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX         = 8'd255;
    localparam logic [COUNT_BITS-1:0] COUNT_FIRST_CMP   = 8'd3;
    localparam logic [COUNT_BITS-1:0] MIN_SAMPLES_RESET = 8'd6;

    // Tolerance factors: 20 percent band
    localparam logic [3:0] TOL_HI = 4'd10;
    localparam logic [3:0] TOL_LO = 4'd8;

    // Comparison symbols
    typedef enum logic [1:0] {
        SYM_SHORTER = 2'd0,
        SYM_EQUAL   = 2'd1,
        SYM_LONGER  = 2'd2
    } t_symbol;

    // One input item as held in the input register
    typedef struct packed {
        logic [DURATION_BITS-1:0] duration;
        logic                     frame_end;
    } t_item;

    // Tolerance compare of a new duration against the one two items back
    function automatic t_symbol tol_compare(input logic [DURATION_BITS-1:0] older,
                                            input logic [DURATION_BITS-1:0] newer);
        logic [PROD_BITS-1:0] new_hi;
        logic [PROD_BITS-1:0] new_lo;
        logic [PROD_BITS-1:0] old_hi;
        logic [PROD_BITS-1:0] old_lo;
        t_symbol              sym;
        new_hi = PROD_BITS'(newer) * PROD_BITS'(TOL_HI);
        new_lo = PROD_BITS'(newer) * PROD_BITS'(TOL_LO);
        old_hi = PROD_BITS'(older) * PROD_BITS'(TOL_HI);
        old_lo = PROD_BITS'(older) * PROD_BITS'(TOL_LO);
        if (new_hi < old_lo) begin
            sym = SYM_SHORTER;
        end else if (old_hi < new_lo) begin
            sym = SYM_LONGER;
        end else begin
            sym = SYM_EQUAL;
        end
        return sym;
    endfunction

endpackage

// File: src/ir_pulse_pattern_hash_top.sv
// ----------------------------------------------------------------------------
// ir_pulse_pattern_hash_top
// IR pulse pattern hash: FNV-1 hash of mark/space tolerance symbols per frame.
// ----------------------------------------------------------------------------
// Accepts one duration item per clock. An item passes an input register and is
// folded into the frame hash in the next cycle by one constant multiply and one
// tolerance compare, so the block sustains one item per cycle; a frame-end item
// writes the result register and a new frame starts right behind it. A frame-end
// item passes the input register and then the result register. Input stalls only
// when a frame-end item meets a result that has not been taken yet. min_samples is
// sampled when the frame result is formed; write it only while the block idles.
module ir_pulse_pattern_hash_top
    import iph_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration: min_samples
    input  logic                     i_cfg_wr_en,
    input  logic [COUNT_BITS-1:0]    i_cfg_wr_data,
    // input items
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [DURATION_BITS-1:0] s_axis_tdata,   // [15:0] duration
    input  logic                     s_axis_tlast,   // frame_end
    // results
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [HASH_BITS-1:0]     m_axis_tdata,   // [31:0] hash_value
    output logic                     m_axis_tuser    // [0] recognised
);

    logic [COUNT_BITS-1:0] r_min_samples;
    t_item                 in_item;
    t_item                 reg_item;
    logic                  reg_valid;
    logic                  core_ready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_samples <= MIN_SAMPLES_RESET;
        end else if (i_cfg_wr_en) begin
            r_min_samples <= i_cfg_wr_data;
        end
    end

    assign in_item.duration  = s_axis_tdata;
    assign in_item.frame_end = s_axis_tlast;

    iph_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (reg_valid),
        .i_ready (core_ready),
        .o_item  (reg_item)
    );

    iph_hash_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_min_samples (r_min_samples),
        .i_valid       (reg_valid),
        .o_ready       (core_ready),
        .i_item        (reg_item),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_hash        (m_axis_tdata),
        .o_recognised  (m_axis_tuser)
    );

endmodule

// File: src/iph_in_reg.sv
// ----------------------------------------------------------------------------
// iph_in_reg
// Input register: captures one item per cycle unless the hash core stalls, and hands it on.
// ----------------------------------------------------------------------------
module iph_in_reg
    import iph_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    // upstream
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    // downstream
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // Take a new item when empty or when the held one moves on
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: src/iph_hash_core.sv
// ----------------------------------------------------------------------------
// iph_hash_core
// Frame state, tolerance compare, FNV-1 fold and the result register.
// ----------------------------------------------------------------------------
module iph_hash_core
    import iph_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [COUNT_BITS-1:0] i_min_samples,
    // item from the input register
    input  logic                  i_valid,
    output logic                  o_ready,
    input  t_item                 i_item,
    // result
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [HASH_BITS-1:0]  o_hash,
    output logic                  o_recognised
);

    logic [DURATION_BITS-1:0] r_dur0;
    logic [DURATION_BITS-1:0] r_dur1;
    logic [COUNT_BITS-1:0]    r_count;
    logic [HASH_BITS-1:0]     r_hash;
    logic                     r_out_valid;
    logic [HASH_BITS-1:0]     r_out_hash;
    logic                     r_out_rec;

    logic [COUNT_BITS-1:0]    n_count;
    logic [HASH_BITS-1:0]     n_hash;
    logic [HASH_BITS-1:0]     hash_mul;
    t_symbol                  sym;
    logic                     advance;
    logic                     recog;

    // Only a frame end needs room in the result register
    assign o_ready = !i_item.frame_end || !r_out_valid || i_ready;
    assign advance = i_valid && o_ready;

    // Compare against the duration two items back, fold into the hash
    always_comb begin
        sym      = tol_compare(r_dur1, i_item.duration);
        hash_mul = r_hash * HASH_PRIME;
        if (r_count >= COUNT_FIRST_CMP) begin
            n_hash = hash_mul ^ HASH_BITS'(sym);
        end else begin
            n_hash = r_hash;
        end
        if (r_count != COUNT_MAX) begin
            n_count = r_count + 1'b1;
        end else begin
            n_count = r_count;
        end
        recog = (n_count >= i_min_samples);
    end

    // Frame state; cleared after each frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur0  <= '0;
            r_dur1  <= '0;
            r_count <= '0;
            r_hash  <= HASH_BASIS;
        end else if (advance) begin
            if (i_item.frame_end) begin
                r_dur0  <= '0;
                r_dur1  <= '0;
                r_count <= '0;
                r_hash  <= HASH_BASIS;
            end else begin
                r_dur0  <= i_item.duration;
                r_dur1  <= r_dur0;
                r_count <= n_count;
                r_hash  <= n_hash;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && i_item.frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && i_item.frame_end) begin
            r_out_hash <= recog ? n_hash : '0;
            r_out_rec  <= recog;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash       = r_out_hash;
    assign o_recognised = r_out_rec;

    // Assertions
    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_out_valid)
        else $error("result valid right after reset");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && i_item.frame_end) |=> (r_count == '0 && r_hash == HASH_BASIS))
        else $error("frame state not cleared after frame end");

    a_count_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !i_item.frame_end) |=> (r_count != '0))
        else $error("sample count did not advance");

    a_unrecognised_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_rec) |-> (r_out_hash == '0))
        else $error("unrecognised frame with nonzero hash");

    a_no_result_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !(advance && i_item.frame_end))
        else $error("result overwritten while stalled");

endmodule

// File: tb/sv/ir_pulse_pattern_hash_top_tb.sv
// ----------------------------------------------------------------------------
// ir_pulse_pattern_hash_top_tb
// Self-checking bench for the IR pulse pattern hash block. Frames of pulse
// durations are streamed in, and each frame result is checked against a
// behavioral copy of the mark/space tolerance compare and the FNV-1 fold.
// A directed part covers the compare boundaries, the extreme durations, short
// frames and the zero minimum. Random frames follow: mostly IR-like mark/space
// patterns with jitter, some noise, and two long frames, one that saturates the
// count. min_samples is changed between phases while the block is idle. Both
// stream sides idle at random, and the receiver holds off once for a long
// stretch so that the block backs up its input.
// ----------------------------------------------------------------------------
module ir_pulse_pattern_hash_top_tb;
    import iph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [HASH_BITS-1:0] hash_value;
        logic                 recognised;
    } t_frame_result;

    // DUT ports; the inputs are driven to known values from time zero
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [COUNT_BITS-1:0]    i_cfg_wr_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [DURATION_BITS-1:0] s_axis_tdata  = '0;   // [15:0] duration
    logic                     s_axis_tlast  = 1'b0; // frame_end
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [HASH_BITS-1:0]     m_axis_tdata;         // [31:0] hash_value
    logic                     m_axis_tuser;         // [0] recognised

    // Stimulus and expected results
    t_item         pulse_q[$];
    t_frame_result hash_expect_q[$];
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    bit            hold_req      = 1'b0;
    bit            in_taken      = 1'b0;
    int            cycle_count   = 0;
    int            mismatch_count = 0;

    // Predictor state
    logic [DURATION_BITS-1:0] dur_hist[2];
    logic [COUNT_BITS-1:0]    frame_count;
    logic [HASH_BITS-1:0]     frame_hash;
    logic [COUNT_BITS-1:0]    min_samples_cfg = MIN_SAMPLES_RESET;

    ir_pulse_pattern_hash_top i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // 20 percent band compare of a duration against the one two items back
    function automatic t_symbol classify_pulse(input logic [DURATION_BITS-1:0] older,
                                               input logic [DURATION_BITS-1:0] newer);
        longint unsigned o = older;
        longint unsigned n = newer;
        if (n * TOL_HI < o * TOL_LO) begin
            return SYM_SHORTER;
        end else if (o * TOL_HI < n * TOL_LO) begin
            return SYM_LONGER;
        end
        return SYM_EQUAL;
    endfunction

    function automatic void clear_frame();
        dur_hist[0] = '0;
        dur_hist[1] = '0;
        frame_count = '0;
        frame_hash  = HASH_BASIS;
    endfunction

    // Fold one accepted item into the frame; a frame end yields one result
    function automatic void fold_pulse(input t_item it);
        t_symbol       sym;
        t_frame_result res;
        if (frame_count >= COUNT_FIRST_CMP) begin
            sym        = classify_pulse(dur_hist[1], it.duration);
            frame_hash = (frame_hash * HASH_PRIME) ^ HASH_BITS'(sym);
        end
        dur_hist[1] = dur_hist[0];
        dur_hist[0] = it.duration;
        if (frame_count < COUNT_MAX) begin
            frame_count++;
        end
        if (it.frame_end) begin
            if (frame_count >= min_samples_cfg) begin
                res = '{hash_value: frame_hash, recognised: 1'b1};
            end else begin
                res = '{hash_value: '0, recognised: 1'b0};
            end
            hash_expect_q.push_back(res);
            clear_frame();
        end
    endfunction

    // Input driver: offers the next pending item, idling at random
    always @(negedge i_clk) begin
        t_item nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
            // item still on offer, hold it
        end else if (pulse_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = pulse_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= nxt.duration;
            s_axis_tlast  <= nxt.frame_end;
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Result receiver: random stalls plus one long hold-off on request
    always @(negedge i_clk) begin
        int  hold_left;
        bit  hold_done;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Monitor: predict on accepted items, check accepted results
    always @(posedge i_clk) begin
        t_frame_result exp_res;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
            if (in_taken) begin
                fold_pulse('{duration: s_axis_tdata, frame_end: s_axis_tlast});
            end
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                if (hash_expect_q.size() == 0) begin
                    $error("unexpected result: hash_value %08h recognised %0b",
                           m_axis_tdata, m_axis_tuser);
                    mismatch_count++;
                end else begin
                    exp_res = hash_expect_q.pop_front();
                    if (m_axis_tdata !== exp_res.hash_value) begin
                        $error("hash_value mismatch: expected %08h, actual %08h",
                               exp_res.hash_value, m_axis_tdata);
                        mismatch_count++;
                    end
                    if (m_axis_tuser !== exp_res.recognised) begin
                        $error("recognised mismatch: expected %0b, actual %0b",
                               exp_res.recognised, m_axis_tuser);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    task automatic push_pulse(input int d, input bit last);
        pulse_q.push_back('{duration: DURATION_BITS'(d), frame_end: last});
    endtask

    // One frame: leading gap, then marks and spaces around two space lengths
    task automatic queue_frame(input int len, input bit noisy);
        int mark_base;
        int space_a;
        int space_b;
        int base;
        int d;
        mark_base = $urandom_range(1) ? $urandom_range(3000, 100) : $urandom_range(50000, 8000);
        space_a   = $urandom_range(3000, 100);
        space_b   = $urandom_range(1) ? space_a * 3 : $urandom_range(50000, 100);
        for (int k = 0; k < len; k++) begin
            if (k == 0) begin
                d = $urandom_range(65535, 5000);
            end else if (noisy || $urandom_range(19) == 0) begin
                case ($urandom_range(3))
                    0:       d = 0;
                    1:       d = 65535;
                    default: d = $urandom_range(65535);
                endcase
            end else begin
                base = (k % 2) ? mark_base : ($urandom_range(1) ? space_a : space_b);
                // jitter of up to 30 percent either way
                d = base - base * 3 / 10 + int'($urandom_range(base * 6 / 10));
                if (d > 65535) begin
                    d = 65535;
                end
            end
            push_pulse(d, k == len - 1);
        end
    endtask

    task automatic queue_frames(input int n_items, input int max_len);
        int sent = 0;
        int len;
        while (sent < n_items) begin
            len = $urandom_range(max_len, 1);
            queue_frame(len, $urandom_range(4) == 0);
            sent += len;
        end
    endtask

    // Wait until every item is in and every result is out, then let it settle
    task automatic drain_results();
        while (pulse_q.size() > 0 || s_axis_tvalid || hash_expect_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_min_samples(input logic [COUNT_BITS-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        min_samples_cfg = val;
    endtask

    initial begin
        clear_frame();
        send_idle_pct = 30;
        recv_idle_pct = 67;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: one-item frame under the reset minimum is too short
        push_pulse(0, 1'b1);
        // Tolerance boundaries and extreme durations
        push_pulse(40000, 1'b0);
        push_pulse(1000, 1'b0);
        push_pulse(50, 1'b0);
        push_pulse(800, 1'b0);    // exactly 20 percent shorter: equal
        push_pulse(50, 1'b0);
        push_pulse(1000, 1'b0);   // back up by 25 percent: equal
        push_pulse(50, 1'b0);
        push_pulse(1251, 1'b0);   // just over the band: longer
        push_pulse(50, 1'b0);
        push_pulse(1000, 1'b0);   // just under the band: shorter
        push_pulse(65535, 1'b0);
        push_pulse(50, 1'b0);
        push_pulse(0, 1'b0);
        push_pulse(65535, 1'b1);
        drain_results();

        // Zero minimum: a one-item frame and a frame with no symbols count
        write_min_samples(8'd0);
        push_pulse(65535, 1'b1);
        push_pulse(1, 1'b0);
        push_pulse(2, 1'b0);
        push_pulse(3, 1'b1);
        queue_frames(90, 12);
        drain_results();

        // Full minimum: a count just below the limit and one saturated well past it
        write_min_samples(8'd255);
        queue_frame(254, 1'b0);
        queue_frame(300, 1'b0);
        queue_frames(20, 10);
        drain_results();

        send_idle_pct = 67;
        recv_idle_pct = 30;
        write_min_samples(8'd3);
        queue_frames(90, 16);
        drain_results();

        write_min_samples(COUNT_BITS'($urandom_range(40, 2)));
        queue_frames(90, 30);
        drain_results();

        // No idling; the receiver holds off while short frames keep coming
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_min_samples(8'd1);
        hold_req = 1'b1;
        queue_frames(80, 4);
        drain_results();

        write_min_samples(MIN_SAMPLES_RESET);
        queue_frames(100, 20);
        drain_results();

        if (mismatch_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
